// File: rtl/core/fft_pkg.sv
// shared types and constants for the radix-2 fft engine
`default_nettype none
package fft_pkg;
  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_ORD,
    ST_OUT
  } state_t;

  // configuration register indexes
  localparam logic CFG_LOG2_SIZE = 1'b0;
  localparam logic CFG_INVERSE   = 1'b1;

  localparam int DATA_W = 23;
  localparam int TW_W   = 16;

  // quarter-wave cosine table, Q1.15, 17 points
  function automatic logic signed [TW_W-1:0] cos_q(input logic [4:0] m);
    logic signed [TW_W-1:0] v;
    case (m)
      5'd0:  v = 16'sd32767;
      5'd1:  v = 16'sd32610;
      5'd2:  v = 16'sd32138;
      5'd3:  v = 16'sd31357;
      5'd4:  v = 16'sd30274;
      5'd5:  v = 16'sd28899;
      5'd6:  v = 16'sd27246;
      5'd7:  v = 16'sd25330;
      5'd8:  v = 16'sd23170;
      5'd9:  v = 16'sd20788;
      5'd10: v = 16'sd18205;
      5'd11: v = 16'sd15447;
      5'd12: v = 16'sd12540;
      5'd13: v = 16'sd9512;
      5'd14: v = 16'sd6393;
      5'd15: v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // full-circle cosine over 64 points
  function automatic logic signed [TW_W-1:0] circ_cos(input logic [5:0] m);
    logic signed [TW_W-1:0] v;
    if (m <= 6'd16) v = cos_q(m[4:0]);
    else if (m <= 6'd32) v = -cos_q(5'(6'd32 - m));
    else if (m <= 6'd48) v = -cos_q(5'(m - 6'd32));
    else v = cos_q(5'(7'd64 - {1'b0, m}));
    return v;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/fft_bfly.sv
// registered twiddle multiply and butterfly add
`default_nettype none
module fft_bfly (
  input  wire logic                             clk,
  input  wire logic                             mul_en,
  input  wire logic signed [fft_pkg::DATA_W-1:0] a_re,
  input  wire logic signed [fft_pkg::DATA_W-1:0] a_im,
  input  wire logic signed [fft_pkg::DATA_W-1:0] b_re,
  input  wire logic signed [fft_pkg::DATA_W-1:0] b_im,
  input  wire logic signed [fft_pkg::TW_W-1:0]   w_re,
  input  wire logic signed [fft_pkg::TW_W-1:0]   w_im,
  output logic signed [fft_pkg::DATA_W-1:0]      top_re,
  output logic signed [fft_pkg::DATA_W-1:0]      top_im,
  output logic signed [fft_pkg::DATA_W-1:0]      bot_re,
  output logic signed [fft_pkg::DATA_W-1:0]      bot_im
);
  localparam int PW = fft_pkg::DATA_W + fft_pkg::TW_W + 1;
  logic signed [PW-1:0] t_re_r, t_im_r;
  logic signed [PW-1:0] t_re_nxt, t_im_nxt;
  logic signed [fft_pkg::DATA_W-1:0] tr, ti;

  // complex product with rounding, registered
  always_comb begin
    t_re_nxt = PW'(b_re * w_re) - PW'(b_im * w_im) + PW'(16384);
    t_im_nxt = PW'(b_re * w_im) + PW'(b_im * w_re) + PW'(16384);
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      t_re_r <= t_re_nxt;
      t_im_r <= t_im_nxt;
    end
  end

  // floor shift and butterfly
  assign tr = fft_pkg::DATA_W'(t_re_r >>> 15);
  assign ti = fft_pkg::DATA_W'(t_im_r >>> 15);
  assign top_re = a_re + tr;
  assign top_im = a_im + ti;
  assign bot_re = a_re - tr;
  assign bot_im = a_im - ti;
endmodule
`default_nettype wire

// File: rtl/core/radix2_fft_engine.sv
// radix-2 decimation-in-time fft engine top level
// Loads N = 2^lg samples (lg is log2_size clamped to 1..MAX_LOG_SIZE; one per request,
// stored bit-reversed), then runs lg*N/2 butterflies on one shared multiplier, each as a
// read, a multiply and two write-back steps (top, then bottom), then unloads N bins in
// order, each read from the store before it is offered. The store's single write port
// and the shared butterfly unit bound the frame rate. in_stall is high from the last
// sample until the last bin is taken.
`default_nettype none
module radix2_fft_engine #(
  parameter int MAX_LOG_SIZE = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [2:0]                       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [15:0]               in_sample_re,
  input  wire logic signed [15:0]               in_sample_im,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [fft_pkg::DATA_W-1:0]     out_re,
  output logic signed [fft_pkg::DATA_W-1:0]     out_im,
  output logic                                  out_last_out
);
  localparam int LW = MAX_LOG_SIZE;
  localparam int DEPTH = 1 << MAX_LOG_SIZE;
  localparam int DW = fft_pkg::DATA_W;

  fft_pkg::state_t state_r, state_nxt;
  logic [2:0] log2_size_r;
  logic inverse_r;
  logic [LW:0] cnt_r;
  logic [2:0] stg_r;
  logic [LW-1:0] grp_r, k_r;
  logic [2:0] lg;
  logic [LW:0] n_val;

  logic [2*DW-1:0] mem [DEPTH];
  logic [2*DW-1:0] rd_a_r, rd_b_r;
  logic [LW-1:0] p_addr, q_addr, ld_addr;
  logic signed [fft_pkg::TW_W-1:0] w_re_r, w_im_r;
  logic signed [DW-1:0] top_re, top_im, bot_re, bot_im;
  logic signed [DW-1:0] bin_re, bin_im;
  logic wr_q_r;
  logic in_acc, out_acc;

  // effective length
  always_comb begin
    if (log2_size_r == 3'd0) lg = 3'd1;
    else if (log2_size_r > 3'(MAX_LOG_SIZE)) lg = 3'(MAX_LOG_SIZE);
    else lg = log2_size_r;
  end
  assign n_val = (LW+1)'(1) << lg;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // bit-reversed load address
  always_comb begin
    ld_addr = '0;
    for (int i = 0; i < LW; i++) begin
      if (i < int'(lg)) ld_addr[int'(lg) - 1 - i] = cnt_r[i];
    end
  end

  // butterfly addresses: p = grp*2*half + k, q = p + half
  always_comb begin
    p_addr = LW'((grp_r << (stg_r + 3'd1)) + k_r);
    q_addr = LW'(p_addr + (LW'(1) << stg_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fft_pkg::ST_LOAD: if (in_acc && cnt_r == n_val - 1'b1) state_nxt = fft_pkg::ST_RD;
      fft_pkg::ST_RD:   state_nxt = fft_pkg::ST_MUL;
      fft_pkg::ST_MUL:  state_nxt = fft_pkg::ST_WR;
      fft_pkg::ST_WR: begin
        if (wr_q_r) begin
          if (stg_r == lg - 3'd1 && k_r == LW'((1 << stg_r) - 1)
              && grp_r == LW'((n_val >> (stg_r + 3'd1)) - 1'b1))
            state_nxt = fft_pkg::ST_ORD;
          else state_nxt = fft_pkg::ST_RD;
        end
      end
      fft_pkg::ST_ORD:  state_nxt = fft_pkg::ST_OUT;
      fft_pkg::ST_OUT: begin
        if (out_acc) begin
          if (out_last_out) state_nxt = fft_pkg::ST_LOAD;
          else state_nxt = fft_pkg::ST_ORD;
        end
      end
      default: state_nxt = fft_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state_r != fft_pkg::ST_LOAD);
    out_valid = (state_r == fft_pkg::ST_OUT);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fft_pkg::ST_LOAD;
      log2_size_r <= 3'd6;
      inverse_r <= 1'b0;
      cnt_r <= '0;
      stg_r <= '0;
      grp_r <= '0;
      k_r <= '0;
      wr_q_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cnt_r <= '0;
        if (cfg_index == fft_pkg::CFG_LOG2_SIZE) log2_size_r <= cfg_data;
        else inverse_r <= cfg_data[0];
      end else if (state_r == fft_pkg::ST_LOAD && in_acc) begin
        if (cnt_r == n_val - 1'b1) begin
          cnt_r <= '0;
          stg_r <= '0;
          grp_r <= '0;
          k_r <= '0;
          wr_q_r <= 1'b0;
        end else cnt_r <= cnt_r + 1'b1;
      end else if (state_r == fft_pkg::ST_WR) begin
        wr_q_r <= !wr_q_r;
        if (wr_q_r) begin
          if (k_r != LW'((1 << stg_r) - 1)) k_r <= k_r + 1'b1;
          else begin
            k_r <= '0;
            if (grp_r != LW'((n_val >> (stg_r + 3'd1)) - 1'b1)) grp_r <= grp_r + 1'b1;
            else begin
              grp_r <= '0;
              stg_r <= stg_r + 3'd1;
            end
          end
        end
      end else if (state_r == fft_pkg::ST_OUT && out_acc) begin
        cnt_r <= out_last_out ? '0 : cnt_r + 1'b1;
      end
    end
  end

  // twiddle lookup, registered at read
  always_ff @(posedge clk) begin
    if (state_r == fft_pkg::ST_RD) begin
      w_re_r <= fft_pkg::circ_cos(6'(k_r << (3'd5 - stg_r)));
      w_im_r <= inverse_r ? fft_pkg::circ_cos(6'((k_r << (3'd5 - stg_r)) + 6'd48))
                          : -fft_pkg::circ_cos(6'((k_r << (3'd5 - stg_r)) + 6'd48));
    end
  end

  // sample store: one write port, two registered read ports held until the next read
  always_ff @(posedge clk) begin
    if (state_r == fft_pkg::ST_LOAD && in_acc)
      mem[ld_addr] <= {DW'(in_sample_re), DW'(in_sample_im)};
    else if (state_r == fft_pkg::ST_WR)
      mem[wr_q_r ? q_addr : p_addr] <= wr_q_r ? {bot_re, bot_im} : {top_re, top_im};
    if (state_r == fft_pkg::ST_ORD) begin
      rd_a_r <= mem[cnt_r[LW-1:0]];
    end else if (state_r == fft_pkg::ST_RD) begin
      rd_a_r <= mem[p_addr];
      rd_b_r <= mem[q_addr];
    end
  end

  fft_bfly u_bfly (
    .clk    (clk),
    .mul_en (state_r == fft_pkg::ST_MUL),
    .a_re   (rd_a_r[2*DW-1:DW]),
    .a_im   (rd_a_r[DW-1:0]),
    .b_re   (rd_b_r[2*DW-1:DW]),
    .b_im   (rd_b_r[DW-1:0]),
    .w_re   (w_re_r),
    .w_im   (w_im_r),
    .top_re (top_re),
    .top_im (top_im),
    .bot_re (bot_re),
    .bot_im (bot_im)
  );

  // unload: optional 1/N floor shift
  assign bin_re = rd_a_r[2*DW-1:DW];
  assign bin_im = rd_a_r[DW-1:0];
  assign out_re = inverse_r ? (bin_re >>> lg) : bin_re;
  assign out_im = inverse_r ? (bin_im >>> lg) : bin_im;
  assign out_last_out = (cnt_r == n_val - 1'b1);
endmodule
`default_nettype wire

// File: tb/tb_radix2_fft_engine.sv
// self-checking testbench for the radix-2 fft engine
`timescale 1ns / 100ps
`default_nettype none
module tb_radix2_fft_engine;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } sample_t;

  typedef struct {
    logic signed [fft_pkg::DATA_W-1:0] re;
    logic signed [fft_pkg::DATA_W-1:0] im;
    logic                              last;
  } bin_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic                              cfg_index = fft_pkg::CFG_LOG2_SIZE;
  logic [2:0]                        cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [15:0]                in_sample_re = '0;
  logic signed [15:0]                in_sample_im = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [fft_pkg::DATA_W-1:0] out_re;
  logic signed [fft_pkg::DATA_W-1:0] out_im;
  logic                              out_last_out;

  radix2_fft_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_re(in_sample_re), .in_sample_im(in_sample_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_re(out_re), .out_im(out_im), .out_last_out(out_last_out)
  );

  // clock, period 4 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sample_t sample_q[$];
  bin_t    bin_q[$];
  int      errors = 0;
  int      samples_sent = 0;
  int      bins_seen = 0;
  int      frames_done = 0;
  int      max_gap = 4;
  int      max_hold = 4;

  // fft predictor state
  logic [2:0] size_reg = 3'd6;
  logic       inv_reg = 1'b0;
  int         fill_count = 0;
  longint     acc_re[64];
  longint     acc_im[64];

  int quarter_cos[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                          23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

  function automatic longint twiddle_cos(int m);
    int k;
    k = m & 63;
    if (k <= 16) return quarter_cos[k];
    else if (k <= 32) return -quarter_cos[32 - k];
    else if (k <= 48) return -quarter_cos[k - 32];
    return quarter_cos[64 - k];
  endfunction

  // butterflies in place over the bit-reversed frame, then queue the bins
  task automatic compute_bins(int lg);
    int     n, half, p, q, m;
    longint wr, wi, tr, ti, ar, ai, br, bi, vr, vi;
    bin_t   b;
    n = 1 << lg;
    for (int s = 0; s < lg; s++) begin
      half = 1 << s;
      for (int base = 0; base < n; base += 2 * half) begin
        for (int k = 0; k < half; k++) begin
          p = base + k;
          q = p + half;
          m = (k << (5 - s)) & 63;
          wr = twiddle_cos(m);
          wi = inv_reg ? twiddle_cos(m + 48) : -twiddle_cos(m + 48);
          br = acc_re[q];
          bi = acc_im[q];
          tr = (br * wr - bi * wi + 16384) >>> 15;
          ti = (br * wi + bi * wr + 16384) >>> 15;
          ar = acc_re[p];
          ai = acc_im[p];
          acc_re[q] = ar - tr;
          acc_im[q] = ai - ti;
          acc_re[p] = ar + tr;
          acc_im[p] = ai + ti;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      vr = inv_reg ? (acc_re[i] >>> lg) : acc_re[i];
      vi = inv_reg ? (acc_im[i] >>> lg) : acc_im[i];
      b.re = vr[fft_pkg::DATA_W-1:0];
      b.im = vi[fft_pkg::DATA_W-1:0];
      b.last = (i == n - 1);
      bin_q.push_back(b);
    end
  endtask

  // store one accepted sample; a full frame yields its bins
  task automatic take_sample(sample_t smp);
    int lg, n, pos;
    lg = (size_reg == 0) ? 1 : (size_reg > 6) ? 6 : size_reg;
    n = 1 << lg;
    if (fill_count >= n) fill_count = 0;
    pos = 0;
    for (int i = 0; i < lg; i++) pos = (pos << 1) | ((fill_count >> i) & 1);
    acc_re[pos] = smp.re;
    acc_im[pos] = smp.im;
    fill_count++;
    if (fill_count == n) begin
      fill_count = 0;
      compute_bins(lg);
    end
  endtask

  // request driver
  int gap_left = 0;
  always @(posedge clk) begin
    logic    busy;
    sample_t smp;
    busy = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        smp.re = in_sample_re;
        smp.im = in_sample_im;
        take_sample(smp);
        samples_sent++;
        busy = 1'b0;
        gap_left = $urandom_range(0, max_gap);
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          smp = sample_q.pop_front();
          in_sample_re <= smp.re;
          in_sample_im <= smp.im;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and one long hold-off
  int hold_left = 0;
  bit held_once = 1'b0;
  always @(posedge clk) begin
    bin_t b;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        bins_seen++;
        if (bin_q.size() == 0) begin
          $error("unexpected bin: re %0d im %0d last %0b", out_re, out_im, out_last_out);
          errors++;
        end else begin
          b = bin_q.pop_front();
          if (out_re !== b.re) begin
            $error("out_re expected %0d actual %0d", b.re, out_re);
            errors++;
          end
          if (out_im !== b.im) begin
            $error("out_im expected %0d actual %0d", b.im, out_im);
            errors++;
          end
          if (out_last_out !== b.last) begin
            $error("out_last_out expected %0b actual %0b", b.last, out_last_out);
            errors++;
          end
          if (b.last) frames_done++;
        end
        hold_left = $urandom_range(0, max_hold);
        if (!held_once && bins_seen == 10) begin
          held_once = 1'b1;
          hold_left = 300;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_random(int count);
    sample_t smp;
    for (int i = 0; i < count; i++) begin
      smp.re = pick_value();
      smp.im = pick_value();
      sample_q.push_back(smp);
    end
  endtask

  task automatic queue_pair(int re, int im);
    sample_t smp;
    smp.re = 16'(re);
    smp.im = 16'(im);
    sample_q.push_back(smp);
  endtask

  // wait until the engine is quiet
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || bin_q.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fft_pkg::CFG_LOG2_SIZE) size_reg = value;
    else inv_reg = value[0];
    fill_count = 0;
  endtask

  initial begin
    int lg, n, rnd_sent;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 64-point forward, receiver held off early in the unload
    // while the next samples wait at the input
    queue_random(66);
    drain();

    // directed: two-point extremes
    write_reg(fft_pkg::CFG_LOG2_SIZE, 3'd1);
    queue_pair(32767, -32768);
    queue_pair(-32768, 32767);
    queue_pair(-32768, -32768);
    queue_pair(-32768, -32768);
    queue_pair(0, 0);
    queue_pair(-1, -1);
    drain();

    // directed: four-point inverse with floor scaling
    write_reg(fft_pkg::CFG_INVERSE, 3'd1);
    write_reg(fft_pkg::CFG_LOG2_SIZE, 3'd2);
    queue_pair(32767, 32767);
    queue_pair(-32768, 1);
    queue_pair(-1, -32768);
    queue_pair(3, -3);
    drain();

    // partial frame, then a write aborts it; zero length acts as two points
    write_reg(fft_pkg::CFG_INVERSE, 3'd0);
    write_reg(fft_pkg::CFG_LOG2_SIZE, 3'd3);
    queue_pair(12345, -12345);
    queue_pair(-32768, 32767);
    queue_pair(1, 1);
    drain();
    write_reg(fft_pkg::CFG_LOG2_SIZE, 3'd0);
    queue_pair(100, -200);
    queue_pair(-32768, 32767);
    drain();

    // oversized length saturates to 64 points, inverse
    write_reg(fft_pkg::CFG_LOG2_SIZE, 3'd7);
    write_reg(fft_pkg::CFG_INVERSE, 3'd1);
    max_gap = 0;
    max_hold = 0;
    queue_random(64);
    drain();

    // random settings, short frames
    rnd_sent = 0;
    while (rnd_sent < 36) begin
      lg = $urandom_range(1, 3);
      n = 1 << lg;
      write_reg(fft_pkg::CFG_LOG2_SIZE, lg[2:0]);
      write_reg(fft_pkg::CFG_INVERSE, 3'($urandom_range(0, 1)));
      max_gap = $urandom_range(0, 1) ? 4 : 0;
      max_hold = $urandom_range(0, 1) ? 4 : 0;
      n = n * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, (1 << lg) - 1);
      queue_random(n);
      rnd_sent += n;
      drain();
    end

    $display("%0d samples sent, %0d bins checked over %0d frames, both directions",
             samples_sent, bins_seen, frames_done);
    $display("lengths 2 to 64, zero and oversized length codes, aborted partial frames");
    if (errors == 0) begin
      $display("tb_radix2_fft_engine OK");
    end else begin
      $display("tb_radix2_fft_engine NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_radix2_fft_engine NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
